// ===== rtl/rgb_3x3_unsharp_sharpen_assert.svh =====
// Assertion macros used by the checker file of the sharpening filter.
`ifndef RGB_3X3_UNSHARP_SHARPEN_ASSERT_SVH
`define RGB_3X3_UNSHARP_SHARPEN_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while dis is high.
`define RGB3US_ASSERT_IMPLY(label, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("rgb3us: assertion failed");

// Next-cycle implication, sampled on clk, disabled while dis is high.
`define RGB3US_ASSERT_NEXT(label, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("rgb3us: assertion failed");

`endif

// ===== rtl/rgb3us_pkg.sv =====
// Package with the types and constants of the 3x3 unsharp sharpening filter.
package rgb3us_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } result_item_t;

  typedef struct packed {
    pixel_t older;
    pixel_t prev;
    pixel_t cur;
  } column_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic interior;
    logic last;
  } stage_ctl_t;

endpackage

// ===== rtl/rgb3us_line_buf.sv =====
// Two line stores that deliver one registered 3-pixel window column per transaction.
module rgb3us_line_buf #(
  parameter int MAX_WIDTH = rgb3us_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  rgb3us_pkg::pixel_t           px,
  output rgb3us_pkg::column_t          column
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  rgb3us_pkg::pixel_t prev_mem  [MAX_WIDTH];
  rgb3us_pkg::pixel_t older_mem [MAX_WIDTH];

  rgb3us_pkg::pixel_t prev_q;
  rgb3us_pkg::pixel_t cur_q;
  rgb3us_pkg::pixel_t older_rd;
  rgb3us_pkg::pixel_t byp_data;
  logic               byp_sel;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  logic               hit;

  // The older row takes what the previous row held in the cycle after the read.
  // A read of the same entry in that cycle gets the pending value instead.
  assign hit = pend && (pend_addr == addr);

  always_ff @(posedge clk) begin
    if (wr) begin
      prev_q         <= prev_mem[addr];
      prev_mem[addr] <= px;
      cur_q          <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      older_mem[pend_addr] <= prev_q;
    end
    if (wr) begin
      older_rd <= older_mem[addr];
      byp_sel  <= hit;
      byp_data <= prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      pend_addr <= addr;
    end
  end

  assign column.older = byp_sel ? byp_data : older_rd;
  assign column.prev  = prev_q;
  assign column.cur   = cur_q;

endmodule

// ===== rtl/rgb3us_window.sv =====
// Window column sums, centre pixels and the per-channel sharpening arithmetic.
module rgb3us_window (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  rgb3us_pkg::stage_ctl_t   s1_ctl,
  input  rgb3us_pkg::column_t      column,
  output logic                     res_valid,
  output rgb3us_pkg::result_item_t res_item
);

  // floor(s / 9) equals (s * 7282) >> 16 for every window sum up to 2295.
  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } col_sum_t;

  rgb3us_pkg::stage_ctl_t s2_ctl;
  col_sum_t               cs0;
  col_sum_t               cs1;
  col_sum_t               cs2;
  col_sum_t               new_sum;
  rgb3us_pkg::pixel_t     mid1;
  rgb3us_pkg::pixel_t     mid2;
  logic [7:0]             sharp_red;
  logic [7:0]             sharp_green;
  logic [7:0]             sharp_blue;

  function automatic logic [9:0] add3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return {2'b00, a} + {2'b00, b} + {2'b00, c};
  endfunction

  function automatic logic [7:0] sharpen(input logic [7:0] centre, input logic [9:0] a,
                                         input logic [9:0] b, input logic [9:0] c);
    logic [11:0] sum;
    logic [24:0] prod;
    logic [9:0]  dbl;
    logic [9:0]  mean;
    logic [9:0]  diff;
    sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
    prod = {13'd0, sum} * {12'd0, DIV9_MUL};
    mean = {2'b00, prod[DIV9_SHIFT +: 8]};
    dbl  = {1'b0, centre, 1'b0};
    diff = dbl - mean;
    if (dbl < mean) begin
      return 8'd0;
    end else if (diff > 10'd255) begin
      return 8'd255;
    end
    return diff[7:0];
  endfunction

  assign new_sum.red   = add3(column.older.red, column.prev.red, column.cur.red);
  assign new_sum.green = add3(column.older.green, column.prev.green, column.cur.green);
  assign new_sum.blue  = add3(column.older.blue, column.prev.blue, column.cur.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl.valid) begin
      cs0  <= cs1;
      cs1  <= cs2;
      cs2  <= new_sum;
      mid1 <= mid2;
      mid2 <= column.prev;
    end
  end

  assign sharp_red   = sharpen(mid1.red, cs0.red, cs1.red, cs2.red);
  assign sharp_green = sharpen(mid1.green, cs0.green, cs1.green, cs2.green);
  assign sharp_blue  = sharpen(mid1.blue, cs0.blue, cs1.blue, cs2.blue);

  assign res_valid          = s2_ctl.valid && s2_ctl.emit;
  assign res_item.red_out   = s2_ctl.interior ? sharp_red : mid1.red;
  assign res_item.green_out = s2_ctl.interior ? sharp_green : mid1.green;
  assign res_item.blue_out  = s2_ctl.interior ? sharp_blue : mid1.blue;
  assign res_item.frame_end = s2_ctl.last;

endmodule

// ===== rtl/rgb_3x3_unsharp_sharpen.sv =====
// Top level of the streaming 3x3 box unsharp-mask sharpening filter for RGB pixels.
//
//   channel   direction  handshake                 payload
//   pixel     in         pixel_valid/pixel_stall   pixel_item (rgb3us_pkg::pixel_item_t)
//   result    out        result_valid/result_stall result_item (rgb3us_pkg::result_item_t)
//   cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One pixel transaction is taken every cycle; a result leaves through the line store read,
// window and output registers after the transaction that completes its window.
// The whole pipeline holds while a result waits under result_stall.
// Reset is synchronous and clears control state only; the line stores hold no reset value.
// A write to the width or height register restarts the frame and keeps the line stores.
module rgb_3x3_unsharp_sharpen #(
  parameter int MAX_WIDTH  = rgb3us_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgb3us_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  rgb3us_pkg::pixel_item_t             pixel_item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output rgb3us_pkg::result_item_t            result_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgb3us_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgb3us_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  function automatic logic [COL_W-1:0] width_last(
      input logic [rgb3us_pkg::CFG_DATA_W-1:0] d);
    logic [rgb3us_pkg::IMAGE_WIDTH_W-1:0] v;
    v = d[rgb3us_pkg::IMAGE_WIDTH_W-1:0];
    if (v == '0) begin
      return '0;
    end else if (32'(v) > MAX_WIDTH) begin
      return COL_W'(MAX_WIDTH - 1);
    end
    return COL_W'(v - 1'b1);
  endfunction

  function automatic logic [ROW_W-1:0] height_last(
      input logic [rgb3us_pkg::CFG_DATA_W-1:0] d);
    logic [rgb3us_pkg::IMAGE_HEIGHT_W-1:0] v;
    v = d[rgb3us_pkg::IMAGE_HEIGHT_W-1:0];
    if (v == '0) begin
      return '0;
    end else if (32'(v) > MAX_HEIGHT) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end
    return ROW_W'(v - 1'b1);
  endfunction

  logic [COL_W-1:0]         w_last;
  logic [ROW_W-1:0]         h_last;
  logic [ROW_W-1:0]         in_row;
  logic [ROW_W-1:0]         in_row_next;
  logic [COL_W-1:0]         in_col;
  logic [COL_W-1:0]         in_col_next;
  logic [ROW_W-1:0]         out_row;
  logic [ROW_W-1:0]         out_row_next;
  logic [COL_W-1:0]         out_col;
  logic [COL_W-1:0]         out_col_next;
  logic                     adv;
  logic                     acc;
  logic                     pixel_phase;
  logic                     wr;
  logic                     emit;
  logic                     interior;
  logic                     last;
  logic                     cfg_hit;
  rgb3us_pkg::pixel_t       px;
  rgb3us_pkg::stage_ctl_t   s1_ctl;
  rgb3us_pkg::column_t      column;
  logic                     res_valid;
  rgb3us_pkg::result_item_t res_item;

  assign cfg_ready   = 1'b1;
  assign adv         = !(result_valid && result_stall);
  assign pixel_stall = !adv;
  assign acc         = pixel_valid && adv;

  assign cfg_hit = cfg_valid && ((cfg_index == rgb3us_pkg::REG_IMAGE_WIDTH) ||
                                 (cfg_index == rgb3us_pkg::REG_IMAGE_HEIGHT));

  // Once the whole frame is in, every transaction drains and carries no pixel.
  assign pixel_phase = in_row <= h_last;
  assign wr          = acc && !(pixel_phase && pixel_item.req_type);
  assign px          = pixel_phase ? {pixel_item.red_in, pixel_item.green_in,
                                      pixel_item.blue_in} : '0;

  assign emit     = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign interior = (out_row != '0) && (out_row < h_last) &&
                    (out_col != '0) && (out_col < w_last);
  assign last     = (out_row == h_last) && (out_col == w_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= width_last(rgb3us_pkg::CFG_DATA_W'(rgb3us_pkg::IMAGE_WIDTH_RST));
      h_last <= height_last(rgb3us_pkg::CFG_DATA_W'(rgb3us_pkg::IMAGE_HEIGHT_RST));
    end else if (cfg_valid) begin
      case (cfg_index)
        rgb3us_pkg::REG_IMAGE_WIDTH: begin
          w_last <= width_last(cfg_data);
        end
        rgb3us_pkg::REG_IMAGE_HEIGHT: begin
          h_last <= height_last(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (cfg_hit) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else if (wr) begin
      if (in_col == w_last) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col == w_last) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= {wr, emit, interior, last};
    end
  end

  rgb3us_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .addr   (in_col),
    .px     (px),
    .column (column)
  );

  rgb3us_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_ctl    (s1_ctl),
    .column    (column),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      result_item <= res_item;
    end
  end

endmodule

// ===== rtl/rgb3us_checker.sv =====
// Port-level assertion checker for the sharpening filter and its bind statement.
`include "rgb_3x3_unsharp_sharpen_assert.svh"

module rgb3us_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     pixel_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input rgb3us_pkg::result_item_t result_item
);

  `RGB3US_ASSERT_NEXT(a_result_hold, rst, result_valid && result_stall, result_valid && $stable(result_item))
  `RGB3US_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !result_valid)
  `RGB3US_ASSERT_IMPLY(a_stall_cause, rst, pixel_stall, result_valid && result_stall)
  `RGB3US_ASSERT_IMPLY(a_no_false_stall, rst, result_valid && result_stall, pixel_stall)

endmodule

bind rgb_3x3_unsharp_sharpen rgb3us_checker u_checker (.*);
